### src/signed_integer_alu_macros.svh
// assertion macros for the signed integer alu
`ifndef SIGNED_INTEGER_ALU_MACROS_SVH
`define SIGNED_INTEGER_ALU_MACROS_SVH

// same-cycle implication
`define SIA_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define SIA_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### src/sia_pkg.sv
// shared types and codes for the signed integer alu
package sia_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_GCD = 5'd5, OP_POW = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
    OP_NOT = 5'd10, OP_ASR = 5'd11, OP_LSL = 5'd12, OP_LSR = 5'd13,
    OP_BITTEST = 5'd14, OP_EQ = 5'd15, OP_GE = 5'd16, OP_LT = 5'd17,
    OP_ABS = 5'd18, OP_LG2 = 5'd19, OP_POPCOUNT = 5'd20
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_NO_VALUE = 2'd2, ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MUL, S_DIV, S_GCD, S_SCAN,
    S_POW_TEST, S_POW_MACC, S_POW_ACCW, S_POW_MSQ, S_POW_SQW, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_MUL_INIT, CMD_MUL_STEP, CMD_DIV_INIT, CMD_DIV_STEP,
    CMD_GCD_INIT, CMD_GCD_STEP, CMD_SCAN_INIT, CMD_SCAN_STEP, CMD_POW_INIT,
    CMD_POW_ACC, CMD_POW_SQ, CMD_OUT
  } cmd_t;

  typedef enum logic [1:0] {
    MSEL_AB, MSEL_ACCX, MSEL_XX
  } msel_t;

  typedef struct packed {
    cmd_t  cmd;
    msel_t msel;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic b_zero;
    logic b_neg;
    logic cnt_last;
    logic gcd_done;
    logic y_zero;
    logic y_lsb;
  } sts_t;

endpackage

### src/sia_ctrl.sv
// controller state machine for the signed integer alu
`include "signed_integer_alu_macros.svh"

module sia_ctrl
  import sia_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output ctl_t ctl,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_MUL: state_nxt = S_MUL;
          OP_DIV, OP_MOD: state_nxt = sts.b_zero ? S_FINISH : S_DIV;
          OP_GCD: state_nxt = S_GCD;
          OP_POW: state_nxt = sts.b_neg ? S_FINISH : S_POW_TEST;
          OP_LG2, OP_POPCOUNT: state_nxt = S_SCAN;
          default: state_nxt = S_FINISH;
        endcase
      end
      S_MUL, S_DIV, S_SCAN: begin
        if (sts.cnt_last) state_nxt = S_FINISH;
      end
      S_GCD: begin
        if (sts.gcd_done) state_nxt = S_FINISH;
      end
      S_POW_TEST: begin
        if (sts.y_zero) state_nxt = S_FINISH;
        else if (sts.y_lsb) state_nxt = S_POW_MACC;
        else state_nxt = S_POW_MSQ;
      end
      S_POW_MACC: begin
        if (sts.cnt_last) state_nxt = S_POW_ACCW;
      end
      S_POW_ACCW: state_nxt = S_POW_MSQ;
      S_POW_MSQ: begin
        if (sts.cnt_last) state_nxt = S_POW_SQW;
      end
      S_POW_SQW: state_nxt = S_POW_TEST;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.cmd   = CMD_NONE;
    ctl.msel  = MSEL_AB;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) ctl.cmd = CMD_LOAD;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_MUL: ctl.cmd = CMD_MUL_INIT;
          OP_DIV, OP_MOD: ctl.cmd = sts.b_zero ? CMD_NONE : CMD_DIV_INIT;
          OP_GCD: ctl.cmd = CMD_GCD_INIT;
          OP_POW: ctl.cmd = sts.b_neg ? CMD_NONE : CMD_POW_INIT;
          OP_LG2, OP_POPCOUNT: ctl.cmd = CMD_SCAN_INIT;
          default: ctl.cmd = CMD_NONE;
        endcase
      end
      S_MUL, S_POW_MACC, S_POW_MSQ: ctl.cmd = CMD_MUL_STEP;
      S_DIV: ctl.cmd = CMD_DIV_STEP;
      S_SCAN: ctl.cmd = CMD_SCAN_STEP;
      S_GCD: begin
        if (!sts.gcd_done) ctl.cmd = CMD_GCD_STEP;
      end
      S_POW_TEST: begin
        if (!sts.y_zero) begin
          ctl.cmd  = CMD_MUL_INIT;
          ctl.msel = sts.y_lsb ? MSEL_ACCX : MSEL_XX;
        end
      end
      S_POW_ACCW: ctl.cmd = CMD_POW_ACC;
      S_POW_SQW: ctl.cmd = CMD_POW_SQ;
      S_FINISH: begin
        if (out_free) ctl.cmd = CMD_OUT;
      end
      default: ctl.cmd = CMD_NONE;
    endcase
  end

  always_comb begin
    if (ctl.cmd == CMD_OUT) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SIA_ASSERT_IMP(a_no_overwrite, ctl.cmd == CMD_OUT, !out_valid_r || out_tready)
  `SIA_ASSERT_NXT(a_accept_dispatch, in_tvalid && in_tready, state_r == S_DISPATCH)
  `SIA_ASSERT_NXT(a_finish_idle, state_r == S_FINISH && out_free,
                  state_r == S_IDLE && out_valid_r)

endmodule

### src/sia_dp.sv
// datapath of the signed integer alu: operands, shared multiplier, divider, gcd, scan
module sia_dp
  import sia_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] lhs,
  input  logic [WIDTH-1:0] rhs,
  input  logic [4:0]       op,
  input  ctl_t             ctl,
  output sts_t             sts,
  output logic [63:0]      out_value,
  output logic [1:0]       out_status
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] a_r, b_r, x_r, y_r, acc_r, p_r, mc_r, mp_r;
  logic [WIDTH-1:0] x_nxt, y_nxt, acc_nxt, p_nxt, mc_nxt, mp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt, k_r, k_nxt;
  op_t              op_r;
  logic [63:0]      out_value_r;
  status_t          out_status_r;

  logic [WIDTH-1:0] a_mag, b_mag, rs, gcd_val, res_v, lg2_v;
  logic [5:0]       sh;
  status_t          res_st;
  logic signed [WIDTH-1:0] a_s, b_s, res_s;

  assign a_s   = signed'(a_r);
  assign b_s   = signed'(b_r);
  assign a_mag = a_r[WIDTH-1] ? (~a_r + 1'b1) : a_r;
  assign b_mag = b_r[WIDTH-1] ? (~b_r + 1'b1) : b_r;
  assign sh    = b_r[5:0];
  assign rs    = {acc_r[WIDTH-2:0], x_r[WIDTH-1]};

  assign sts.op       = op_r;
  assign sts.b_zero   = (b_r == '0);
  assign sts.b_neg    = b_r[WIDTH-1];
  assign sts.cnt_last = (cnt_r == CW'(WIDTH - 1));
  assign sts.gcd_done = (x_r == '0) || (y_r == '0);
  assign sts.y_zero   = (y_r == '0);
  assign sts.y_lsb    = y_r[0];

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    acc_nxt = acc_r;
    p_nxt   = p_r;
    mc_nxt  = mc_r;
    mp_nxt  = mp_r;
    cnt_nxt = cnt_r;
    k_nxt   = k_r;
    case (ctl.cmd)
      CMD_MUL_INIT: begin
        p_nxt   = '0;
        cnt_nxt = '0;
        case (ctl.msel)
          MSEL_ACCX: begin
            mc_nxt = acc_r;
            mp_nxt = x_r;
          end
          MSEL_XX: begin
            mc_nxt = x_r;
            mp_nxt = x_r;
          end
          default: begin
            mc_nxt = a_r;
            mp_nxt = b_r;
          end
        endcase
      end
      CMD_MUL_STEP: begin
        if (mp_r[0]) p_nxt = p_r + mc_r;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
      end
      CMD_DIV_INIT: begin
        x_nxt   = a_mag;
        y_nxt   = b_mag;
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      CMD_DIV_STEP: begin
        if (rs >= y_r) begin
          acc_nxt = rs - y_r;
          x_nxt   = {x_r[WIDTH-2:0], 1'b1};
        end else begin
          acc_nxt = rs;
          x_nxt   = {x_r[WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      CMD_GCD_INIT: begin
        x_nxt = a_mag;
        y_nxt = b_mag;
        k_nxt = '0;
      end
      CMD_GCD_STEP: begin
        if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r >= y_r) begin
          x_nxt = (x_r - y_r) >> 1;
        end else begin
          y_nxt = (y_r - x_r) >> 1;
        end
      end
      CMD_SCAN_INIT: begin
        x_nxt   = a_r;
        y_nxt   = '0;
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      CMD_SCAN_STEP: begin
        acc_nxt = acc_r + WIDTH'(x_r[0]);
        if (x_r[0]) y_nxt = WIDTH'(cnt_r);
        x_nxt   = x_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
      end
      CMD_POW_INIT: begin
        acc_nxt = WIDTH'(1);
        x_nxt   = a_r;
        y_nxt   = b_r;
      end
      CMD_POW_ACC: begin
        acc_nxt = p_r;
        p_nxt   = '0;
        mc_nxt  = x_r;
        mp_nxt  = x_r;
        cnt_nxt = '0;
      end
      CMD_POW_SQ: begin
        x_nxt = p_r;
        y_nxt = y_r >> 1;
      end
      default: begin
      end
    endcase
  end

  assign gcd_val = (x_r | y_r) << k_r;
  assign lg2_v   = y_r;

  always_comb begin
    res_v  = '0;
    res_st = ST_OK;
    case (op_r)
      OP_ADD: res_v = a_r + b_r;
      OP_SUB: res_v = a_r - b_r;
      OP_MUL: res_v = p_r;
      OP_DIV: begin
        if (b_r == '0) res_st = ST_DIV_ZERO;
        else res_v = (a_r[WIDTH-1] ^ b_r[WIDTH-1]) ? (~x_r + 1'b1) : x_r;
      end
      OP_MOD: begin
        if (b_r == '0) res_st = ST_DIV_ZERO;
        else res_v = a_r[WIDTH-1] ? (~acc_r + 1'b1) : acc_r;
      end
      OP_GCD: begin
        if (gcd_val == '0 || gcd_val[WIDTH-1]) res_st = ST_DIV_ZERO;
        else res_v = gcd_val;
      end
      OP_POW: begin
        if (b_r[WIDTH-1]) res_st = ST_NO_VALUE;
        else res_v = acc_r;
      end
      OP_AND: res_v = a_r & b_r;
      OP_OR: res_v = a_r | b_r;
      OP_XOR: res_v = a_r ^ b_r;
      OP_NOT: res_v = ~a_r;
      OP_ASR: res_v = a_s >>> sh;
      OP_LSL: res_v = a_r << sh;
      OP_LSR: res_v = a_r >> sh;
      OP_BITTEST: res_v = WIDTH'((a_s >>> sh) & WIDTH'(1));
      OP_EQ: res_v = WIDTH'(a_r == b_r);
      OP_GE: res_v = WIDTH'(a_s >= b_s);
      OP_LT: res_v = WIDTH'(a_s < b_s);
      OP_ABS: res_v = a_mag;
      OP_LG2: begin
        if (a_r[WIDTH-1] || a_r == '0) res_st = ST_RANGE;
        else res_v = lg2_v;
      end
      OP_POPCOUNT: res_v = acc_r;
      default: res_st = ST_RANGE;
    endcase
  end

  assign res_s = signed'(res_v);

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    p_r   <= p_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
    if (ctl.cmd == CMD_LOAD) begin
      a_r  <= lhs;
      b_r  <= rhs;
      op_r <= op_t'(op);
    end
    if (ctl.cmd == CMD_OUT) begin
      out_value_r  <= 64'(res_s);
      out_status_r <= res_st;
    end
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

### src/signed_integer_alu.sv
// signed integer alu top level: stream ports, controller and datapath
// single-step ops go from dispatch straight to the finish state; mul, div, mod, lg2 and
// popcount take one bit per cycle in the shared units, gcd is a binary gcd with one
// subtract or shift per cycle, and pow does one or two shift-add multiplies per exponent bit
// one transaction at a time; the next is taken once the result sits in the output
// register, which stalls while it holds a result and out_tready is low
// synchronous active-low reset clears the controller and output valid, no clearing pass
module signed_integer_alu
  import sia_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // lhs, rhs
  input  logic [4:0]   in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // value
  output logic [1:0]   out_tuser  // status
);

  ctl_t ctl;
  sts_t sts;

  sia_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .sts        (sts)
  );

  sia_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .lhs        (in_tdata[WIDTH-1:0]),
    .rhs        (in_tdata[64 +: WIDTH]),
    .op         (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule

### sim/signed_integer_alu_checker.sv
// predictor and result checker for the signed integer alu
module signed_integer_alu_checker
  import sia_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,  // lhs, rhs
  input  logic [4:0]   in_tuser,  // op
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata, // value
  input  logic [1:0]   out_tuser, // status
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } alu_result_t;

  alu_result_t results_due[$];

  function automatic alu_result_t alu_compute(logic [4:0] op, logic [63:0] a, logic [63:0] b);
    alu_result_t r;
    logic [63:0] ma, mb, q, t, x, y, acc;
    int sh;
    r.value  = '0;
    r.status = ST_OK;
    sh = int'(b[5:0]);
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) r.status = ST_DIV_ZERO;
        else if (op == OP_DIV) begin
          q = ma / mb;
          r.value = (a[63] != b[63]) ? -q : q;
        end else begin
          q = ma % mb;
          r.value = a[63] ? -q : q;
        end
      end
      OP_GCD: begin
        while (mb != 0) begin
          t = ma % mb;
          ma = mb;
          mb = t;
        end
        if (ma == 0 || ma[63]) r.status = ST_DIV_ZERO;
        else r.value = ma;
      end
      OP_POW: begin
        if (b[63]) r.status = ST_NO_VALUE;
        else begin
          acc = 64'd1;
          x = a;
          y = b;
          while (y != 0) begin
            if (y[0]) acc = acc * x;
            x = x * x;
            y = y >> 1;
          end
          r.value = acc;
        end
      end
      OP_AND: r.value = a & b;
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_NOT: r.value = ~a;
      OP_ASR: r.value = $signed(a) >>> sh;
      OP_LSL: r.value = a << sh;
      OP_LSR: r.value = a >> sh;
      OP_BITTEST: r.value = {63'd0, a[sh]};
      OP_EQ: r.value = {63'd0, a == b};
      OP_GE: r.value = {63'd0, $signed(a) >= $signed(b)};
      OP_LT: r.value = {63'd0, $signed(a) < $signed(b)};
      OP_ABS: r.value = ma;
      OP_LG2: begin
        if (a[63] || a == 0) r.status = ST_RANGE;
        else for (int i = 0; i < 64; i++) if (a[i]) r.value = 64'(i);
      end
      OP_POPCOUNT: r.value = 64'($countones(a));
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  assign pending = results_due.size();

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      errors = 0;
    end else begin
      if (in_tvalid && in_tready)
        results_due.push_back(alu_compute(in_tuser, in_tdata[63:0], in_tdata[127:64]));
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %h status %0d", $time, out_tdata, out_tuser);
        end else begin
          want = results_due.pop_front();
          if (out_tdata !== want.value) begin
            errors++;
            $display("%0t: value expected %h actual %h", $time, want.value, out_tdata);
          end
          if (out_tuser !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          end
        end
      end
    end
  end

endmodule

### sim/signed_integer_alu_tb.sv
// testbench top for the signed integer alu: clock, reset, stimulus and verdict
module signed_integer_alu_tb;
  import sia_pkg::*;

  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINUS_ONE = '1;
  localparam int RANDOM_ITEMS = 1525;
  localparam int CYCLE_LIMIT = 3000000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;  // lhs, rhs
  logic [4:0]   in_tuser;  // op
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata; // value
  logic [1:0]   out_tuser; // status
  int           errors;
  int           pending;
  logic         quiet;
  logic         hold_off;
  int           cycles;

  signed_integer_alu DUT (.*);

  signed_integer_alu_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side stalls in short bursts, with one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        out_tready <= 1'b1;
        held = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_op(logic [4:0] op, logic [63:0] lhs, logic [63:0] rhs);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rhs, lhs};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
      2: return -({{32{1'b0}}, $urandom} >> $urandom_range(0, 31));
      3: return $urandom_range(0, 3) == 0 ? MOST_NEG : ($urandom_range(0, 1) ? MOST_POS : 64'd0);
      4: return 64'($signed($urandom_range(0, 16)) - 8);
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  initial begin
    logic [4:0]  op;
    logic [63:0] lhs, rhs;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    quiet     = 1'b0;
    hold_off  = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_op(OP_ADD, MOST_POS, 64'd1);
    send_op(OP_SUB, MOST_NEG, 64'd1);
    send_op(OP_MUL, MOST_NEG, MINUS_ONE);
    send_op(OP_DIV, 64'd7, 64'd0);
    send_op(OP_MOD, 64'd7, 64'd0);
    send_op(OP_DIV, MOST_NEG, MINUS_ONE);
    send_op(OP_MOD, MOST_NEG, MINUS_ONE);
    send_op(OP_DIV, -64'd7, 64'd2);
    send_op(OP_MOD, -64'd7, 64'd2);
    send_op(OP_GCD, 64'd0, 64'd0);
    send_op(OP_GCD, MOST_NEG, 64'd0);
    send_op(OP_GCD, -64'd12, 64'd18);
    send_op(OP_POW, 64'd3, MINUS_ONE);
    send_op(OP_POW, MINUS_ONE, MOST_POS);
    send_op(OP_AND, MINUS_ONE, MOST_NEG);
    send_op(OP_OR, 64'd5, 64'd10);
    send_op(OP_XOR, MOST_POS, MINUS_ONE);
    send_op(OP_NOT, 64'd0, 64'd0);
    send_op(OP_ASR, MOST_NEG, 64'd63);
    send_op(OP_LSL, 64'd1, 64'd127);
    send_op(OP_LSR, MINUS_ONE, 64'd64);
    send_op(OP_BITTEST, MOST_NEG, MINUS_ONE);
    send_op(OP_ABS, MOST_NEG, 64'd0);
    send_op(OP_LG2, 64'd0, 64'd0);
    send_op(5'd31, MOST_POS, MOST_POS);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == 700) begin
        in_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      if (i == RANDOM_ITEMS - 150) quiet = 1'b1;
      op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(21, 31)) : 5'($urandom_range(0, 20));
      lhs = pick_operand();
      rhs = pick_operand();
      if (op == OP_POW && !rhs[63] && $urandom_range(0, 15) != 0)
        rhs = 64'($urandom_range(0, 20));
      send_op(op, lhs, rhs);
    end

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
